### src/disk_sector_position_tracker_assert.svh
// Assertion macros for the disk sector position tracker checker.
// Depends on nothing; the including module must have clk and rst in scope.
`ifndef DISK_SECTOR_POSITION_TRACKER_ASSERT_SVH
`define DISK_SECTOR_POSITION_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DSPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dspt_pkg.sv
// Shared types and constants for the disk sector position tracker.
// No dependencies; every module of the block imports this package.
`default_nettype none

package dspt_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SECTORS_PER_TRACK    = 3'd0;
  localparam logic [2:0] REG_FIRST_SECTOR_ID      = 3'd1;
  localparam logic [2:0] REG_SIDE_COUNT           = 3'd2;
  localparam logic [2:0] REG_TRACK_COUNT          = 3'd3;
  localparam logic [2:0] REG_RESERVED_TRACK_COUNT = 3'd4;
  localparam logic [2:0] REG_SIDES_INTERLEAVED    = 3'd5;
  localparam logic [2:0] REG_RECORDS_PER_SECTOR   = 3'd6;
  localparam logic [2:0] REG_BLOCK_SHIFT          = 3'd7;

  // Register values after reset.
  localparam logic [6:0] RST_SECTORS_PER_TRACK    = 7'd9;
  localparam logic [7:0] RST_FIRST_SECTOR_ID      = 8'd193;
  localparam logic [1:0] RST_SIDE_COUNT           = 2'd1;
  localparam logic [7:0] RST_TRACK_COUNT          = 8'd40;
  localparam logic [7:0] RST_RESERVED_TRACK_COUNT = 8'd0;
  localparam logic       RST_SIDES_INTERLEAVED    = 1'b0;
  localparam logic [6:0] RST_RECORDS_PER_SECTOR   = 7'd4;
  localparam logic [2:0] RST_BLOCK_SHIFT          = 3'd3;

  // Input request kinds.
  localparam logic KIND_SET     = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // Disk layout configuration.
  typedef struct packed {
    logic [6:0] sectors_per_track;
    logic [7:0] first_sector_id;
    logic [1:0] side_count;
    logic [7:0] track_count;
    logic [7:0] reserved_track_count;
    logic       sides_interleaved;
    logic [6:0] records_per_sector;
    logic [2:0] block_shift;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_set;
    logic load_adv;
    logic step;
    logic commit;
    logic set_full;
    logic mul1;
    logic mul2;
    logic fin;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic carry;
    logic step_full;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### src/dspt_cfg.sv
// Configuration register file of the disk sector position tracker.
// Depends on dspt_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module dspt_cfg
  import dspt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  // Writes are always taken; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  // Register writes decoded by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sectors_per_track    <= RST_SECTORS_PER_TRACK;
      cfg.first_sector_id      <= RST_FIRST_SECTOR_ID;
      cfg.side_count           <= RST_SIDE_COUNT;
      cfg.track_count          <= RST_TRACK_COUNT;
      cfg.reserved_track_count <= RST_RESERVED_TRACK_COUNT;
      cfg.sides_interleaved    <= RST_SIDES_INTERLEAVED;
      cfg.records_per_sector   <= RST_RECORDS_PER_SECTOR;
      cfg.block_shift          <= RST_BLOCK_SHIFT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SECTORS_PER_TRACK:    cfg.sectors_per_track    <= cfg_data[6:0];
        REG_FIRST_SECTOR_ID:      cfg.first_sector_id      <= cfg_data;
        REG_SIDE_COUNT:           cfg.side_count           <= cfg_data[1:0];
        REG_TRACK_COUNT:          cfg.track_count          <= cfg_data;
        REG_RESERVED_TRACK_COUNT: cfg.reserved_track_count <= cfg_data;
        REG_SIDES_INTERLEAVED:    cfg.sides_interleaved    <= cfg_data[0];
        REG_RECORDS_PER_SECTOR:   cfg.records_per_sector   <= cfg_data[6:0];
        REG_BLOCK_SHIFT:          cfg.block_shift          <= cfg_data[2:0];
      endcase
    end
  end

endmodule

`default_nettype wire

### src/dspt_ctrl.sv
// Controller state machine of the disk sector position tracker.
// Depends on dspt_pkg for the command and status structs.
`default_nettype none

module dspt_ctrl
  import dspt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    kind,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADV  = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_HOLD = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_SET) begin
            cmd.load_set = 1'b1;
            state_next   = ST_MUL1;
          end else begin
            cmd.load_adv = 1'b1;
            state_next   = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        // One whole track of carry is taken per cycle.
        if (!sts.carry) begin
          cmd.commit = 1'b1;
          state_next = ST_MUL1;
        end else if (sts.step_full) begin
          cmd.set_full = 1'b1;
          state_next   = ST_MUL1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### src/dspt_dp.sv
// Datapath of the disk sector position tracker: position, carry step,
// block index arithmetic and the output register. Depends on dspt_pkg.
`default_nettype none

module dspt_dp
  import dspt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic        side_in,
  input  logic [7:0]  track_in,
  input  logic [7:0]  sector_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        side_out,
  output logic [7:0]  track_out,
  output logic [7:0]  sector_out,
  output logic [15:0] block_index,
  output logic        disk_full
);

  // Architectural position state.
  logic        cur_side;
  logic [7:0]  cur_track;
  logic [7:0]  cur_sector;
  logic [15:0] cur_block;
  logic        full_flag;

  // Working position during an advance.
  logic [1:0]  side_w;
  logic [8:0]  trk_w;
  logic [8:0]  sec_w;

  // Block index pipeline registers.
  logic [14:0] prod1;
  logic        below;
  logic [21:0] prod2;
  logic        neg;

  // Effective layout values.
  logic [6:0]  spt_eff;
  logic [1:0]  sides;
  logic [8:0]  limit;
  logic [8:0]  tc_ext;

  // Carry step results.
  logic [1:0]  side_inc;
  logic [8:0]  trk_inc;
  logic [1:0]  side_step;
  logic [8:0]  trk_step;
  logic [8:0]  sec_step;
  logic        step_full;

  // Block index arithmetic.
  logic [7:0]  trk_diff;
  logic [14:0] prod1_c;
  logic [8:0]  sec_diff;
  logic [16:0] lin;
  logic [21:0] prod2_c;
  logic [3:0]  shamt;
  logic [21:0] shifted;
  logic [15:0] blk_c;

  // A zero sector count acts as one; side counts of two and three act as two.
  assign spt_eff = (cfg.sectors_per_track == 7'd0) ? 7'd1 : cfg.sectors_per_track;
  assign sides   = cfg.side_count[1] ? 2'd2 : 2'd1;
  assign limit   = {1'b0, cfg.first_sector_id} + {2'b00, spt_eff};
  assign tc_ext  = {1'b0, cfg.track_count};

  // One track of carry: the side or the track steps first by mode.
  assign side_inc = side_w + 2'd1;
  assign trk_inc  = trk_w + 9'd1;
  assign sec_step = sec_w - {2'b00, spt_eff};

  always_comb begin
    side_step = side_w;
    trk_step  = trk_w;
    step_full = 1'b0;
    if (cfg.sides_interleaved) begin
      side_step = side_inc;
      if (side_inc >= sides) begin
        trk_step  = trk_inc;
        side_step = side_inc - sides;
        step_full = (trk_inc >= tc_ext);
      end
    end else begin
      trk_step = trk_inc;
      if (trk_inc >= tc_ext) begin
        side_step = side_inc;
        trk_step  = trk_inc - tc_ext;
        step_full = (side_inc >= sides);
      end
    end
  end

  assign sts.carry     = (sec_w >= limit);
  assign sts.step_full = step_full;
  assign sts.out_free  = !out_valid || out_ready;

  // First stage: whole tracks past the reserved area times sectors per track.
  assign trk_diff = cur_track - cfg.reserved_track_count;
  assign prod1_c  = {7'd0, trk_diff} * {8'd0, spt_eff};

  // Second stage: add the sector offset, then scale by records per sector.
  assign sec_diff = {1'b0, cur_sector} - {1'b0, cfg.first_sector_id};
  assign lin      = {2'b00, prod1} + {{8{sec_diff[8]}}, sec_diff};
  assign prod2_c  = {7'd0, lin[14:0]} * {15'd0, cfg.records_per_sector};

  // Third stage: shift to blocks, one more place on a two-sided layout.
  assign shamt   = {1'b0, cfg.block_shift} + {3'b000, cfg.side_count[1]};
  assign shifted = prod2 >> shamt;
  assign blk_c   = neg ? 16'd0 : ((|shifted[21:16]) ? 16'hFFFF : shifted[15:0]);

  // Position, flag and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_side   <= 1'b0;
      cur_track  <= 8'd0;
      cur_sector <= 8'd0;
      cur_block  <= 16'd0;
      full_flag  <= 1'b0;
    end else begin
      if (cmd.load_set) begin
        cur_side   <= side_in;
        cur_track  <= track_in;
        cur_sector <= cfg.first_sector_id;
      end
      if (cmd.commit) begin
        cur_side   <= side_w[0];
        cur_track  <= trk_w[7:0];
        cur_sector <= sec_w[7:0];
      end
      if (cmd.set_full) begin
        full_flag <= 1'b1;
      end
      if (cmd.fin) begin
        cur_block <= blk_c;
      end
    end
  end

  // Working registers of the advance loop and the block pipeline.
  always_ff @(posedge clk) begin
    if (cmd.load_adv) begin
      side_w <= {1'b0, cur_side};
      trk_w  <= {1'b0, cur_track};
      sec_w  <= {1'b0, cur_sector} + {1'b0, sector_count};
    end else if (cmd.step) begin
      side_w <= side_step;
      trk_w  <= trk_step;
      sec_w  <= sec_step;
    end
    if (cmd.mul1) begin
      prod1 <= prod1_c;
      below <= (cur_track < cfg.reserved_track_count);
    end
    if (cmd.mul2) begin
      prod2 <= prod2_c;
      neg   <= below || lin[16];
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      side_out    <= cur_side;
      track_out   <= cur_track;
      sector_out  <= cur_sector;
      block_index <= cur_block;
      disk_full   <= full_flag;
    end
  end

endmodule

`default_nettype wire

### src/disk_sector_position_tracker.sv
// Disk sector position tracker: a request is taken when the tracker is
// idle and gives one result. A set-position request passes through the
// multiply, finish and hold states before the tracker is ready again;
// an advance first runs the carry loop, which subtracts one track of
// sectors per cycle, once per whole track carried (at most 510 with one
// sector per track, and 1 or 2 on typical layouts). The block index
// then passes through two registered multiplies and a shift stage.
// The result sits in an output register, so the next request is accepted
// while it waits. There is no clearing pass after reset.
// Depends on dspt_pkg, dspt_cfg, dspt_ctrl and dspt_dp.
`default_nettype none

module disk_sector_position_tracker
  import dspt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic        side_in,
  input  logic [7:0]  track_in,
  input  logic [7:0]  sector_count,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        side_out,
  output logic [7:0]  track_out,
  output logic [7:0]  sector_out,
  output logic [15:0] block_index,
  output logic        disk_full
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Layout registers.
  dspt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencing of each request.
  dspt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Position arithmetic and result register.
  dspt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .side_in      (side_in),
    .track_in     (track_in),
    .sector_count (sector_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .side_out     (side_out),
    .track_out    (track_out),
    .sector_out   (sector_out),
    .block_index  (block_index),
    .disk_full    (disk_full)
  );

endmodule

`default_nettype wire

### src/dspt_checker.sv
// Port-level checker for the disk sector position tracker, bound to the
// top level. Depends on the assertion macro header.
`default_nettype none

`include "disk_sector_position_tracker_assert.svh"

module dspt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        side_out,
  input logic [7:0]  track_out,
  input logic [7:0]  sector_out,
  input logic [15:0] block_index,
  input logic        disk_full
);

  logic [1:0] pending;
  logic       seen_full;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests accepted whose results are not yet taken, and the sticky flag seen.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 2'd0;
      seen_full <= 1'b0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc && disk_full) begin
        seen_full <= 1'b1;
      end
    end
  end

  `DSPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(side_out) && $stable(track_out) && $stable(sector_out) && $stable(block_index) && $stable(disk_full), "result changed while stalled")
  `DSPT_ASSERT_NOW(a_full_sticky, out_valid && seen_full, disk_full, "disk full flag dropped")
  `DSPT_ASSERT_NOW(a_pending_max, 1'b1, pending != 2'd3, "more than two requests in flight")
  `DSPT_ASSERT_NOW(a_no_invented, out_valid, pending != 2'd0, "result without a request")

endmodule

bind disk_sector_position_tracker dspt_checker u_dspt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .side_out    (side_out),
  .track_out   (track_out),
  .sector_out  (sector_out),
  .block_index (block_index),
  .disk_full   (disk_full)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the disk sector position tracker.
// Drives a directed table and then random phases under different layouts, and
// checks every result against an in-bench position predictor or a typed table entry. Needs dspt_pkg.
`timescale 1ns / 1ps

module tb_top;
  import dspt_pkg::*;

  // Expected result of one request.
  typedef struct packed {
    logic        side;
    logic [7:0]  track;
    logic [7:0]  sector;
    logic [15:0] block;
    logic        full;
  } position_t;

  // One row of the directed table: a register write or a request.
  typedef struct packed {
    logic       is_cfg;
    logic [2:0] reg_idx;
    logic [7:0] reg_val;
    logic       kind;
    logic       side;
    logic [7:0] track;
    logic [7:0] count;
    logic       typed;
    position_t  want;
  } script_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic        side_in;
  logic [7:0]  track_in;
  logic [7:0]  sector_count;
  logic        out_valid;
  logic        out_ready;
  logic        side_out;
  logic [7:0]  track_out;
  logic [7:0]  sector_out;
  logic [15:0] block_index;
  logic        disk_full;

  // Layout mirror and tracked head position of the predictor.
  cfg_t        layout;
  logic        head_side;
  logic [7:0]  head_track;
  logic [7:0]  head_sector;
  logic [15:0] head_block;
  logic        disk_full_seen;

  position_t   pending_positions[$];
  script_row_t script[$];
  int unsigned mismatch_count;
  int unsigned positions_seen;

  disk_sector_position_tracker u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .side_in      (side_in),
    .track_in     (track_in),
    .sector_count (sector_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .side_out     (side_out),
    .track_out    (track_out),
    .sector_out   (sector_out),
    .block_index  (block_index),
    .disk_full    (disk_full)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A zero sectors-per-track setting behaves as one sector.
  function automatic int unsigned sectors_on_track();
    return (layout.sectors_per_track == 0) ? 1 : int'(layout.sectors_per_track);
  endfunction

  // Side counts of zero and three act as one and two sides.
  function automatic int unsigned sides_in_use();
    return (layout.side_count >= 2) ? 2 : 1;
  endfunction

  // Allocation block of a track and sector, clamped at both ends.
  function automatic logic [15:0] block_of(input logic [7:0] trk, input logic [7:0] sec);
    int          linear;
    int unsigned scaled;
    int unsigned shift;
    if (trk < layout.reserved_track_count) return 16'd0;
    linear = (int'(trk) - int'(layout.reserved_track_count)) * int'(sectors_on_track())
           + int'(sec) - int'(layout.first_sector_id);
    if (linear < 0) return 16'd0;
    scaled = linear * int'(layout.records_per_sector);
    shift  = 32'(layout.block_shift) + ((sides_in_use() == 2) ? 1 : 0);
    scaled = scaled >> shift;
    return (scaled > 65535) ? 16'hFFFF : scaled[15:0];
  endfunction

  // Applies one request to the tracked position and returns the new result.
  function automatic position_t predict_position(input logic k, input logic sd,
                                                 input logic [7:0] trk, input logic [7:0] cnt);
    int unsigned spt;
    int unsigned sides;
    int unsigned limit;
    int unsigned sec;
    int unsigned s;
    int unsigned t;
    logic        ran_out;
    if (k == KIND_SET) begin
      head_side   = sd;
      head_track  = trk;
      head_sector = layout.first_sector_id;
    end else begin
      spt     = sectors_on_track();
      sides   = sides_in_use();
      limit   = 32'(layout.first_sector_id) + spt;
      sec     = 32'(head_sector) + 32'(cnt);
      s       = 32'(head_side);
      t       = 32'(head_track);
      ran_out = 1'b0;
      // Carry whole tracks; the step order depends on the interleave mode.
      while (sec >= limit && !ran_out) begin
        sec = sec - spt;
        if (layout.sides_interleaved) begin
          s = s + 1;
          if (s >= sides) begin
            t = t + 1;
            s = s - sides;
            if (t >= 32'(layout.track_count)) ran_out = 1'b1;
          end
        end else begin
          t = t + 1;
          if (t >= 32'(layout.track_count)) begin
            s = s + 1;
            t = t - 32'(layout.track_count);
            if (s >= sides) ran_out = 1'b1;
          end
        end
      end
      // Running off the disk keeps the old position and latches the flag.
      if (ran_out) begin
        disk_full_seen = 1'b1;
      end else begin
        head_side   = s[0];
        head_track  = t[7:0];
        head_sector = sec[7:0];
      end
    end
    head_block = block_of(head_track, head_sector);
    return {head_side, head_track, head_sector, head_block, disk_full_seen};
  endfunction

  function automatic void compare_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Compares the result on the output ports with the oldest expectation.
  function automatic void check_position();
    position_t want;
    if (pending_positions.size() == 0) begin
      $error("unexpected result: side %0d track %0d sector %0d block %0d full %0d",
             side_out, track_out, sector_out, block_index, disk_full);
      mismatch_count++;
    end else begin
      want = pending_positions.pop_front();
      compare_field("side_out", 16'(want.side), 16'(side_out));
      compare_field("track_out", 16'(want.track), 16'(track_out));
      compare_field("sector_out", 16'(want.sector), 16'(sector_out));
      compare_field("block_index", want.block, block_index);
      compare_field("disk_full", 16'(want.full), 16'(disk_full));
    end
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input logic [7:0] v);
    script_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = v;
    script      = {script, row};
  endfunction

  function automatic void add_req(input logic k, input logic sd, input logic [7:0] trk,
                                  input logic [7:0] cnt, input logic typed,
                                  input position_t want);
    script_row_t row;
    row       = '0;
    row.kind  = k;
    row.side  = sd;
    row.track = trk;
    row.count = cnt;
    row.typed = typed;
    row.want  = want;
    script    = {script, row};
  endfunction

  function automatic int unsigned pick_gap(input logic burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Writes one register; unused upper data bits carry junk.
  task automatic write_register(input logic [2:0] idx, input logic [7:0] v);
    logic [7:0] junk;
    logic [7:0] word;
    junk = 8'($urandom_range(0, 255));
    word = v;
    case (idx)
      REG_SECTORS_PER_TRACK: begin
        word = {junk[7], v[6:0]};
        layout.sectors_per_track = v[6:0];
      end
      REG_FIRST_SECTOR_ID:      layout.first_sector_id = v;
      REG_SIDE_COUNT: begin
        word = {junk[7:2], v[1:0]};
        layout.side_count = v[1:0];
      end
      REG_TRACK_COUNT:          layout.track_count = v;
      REG_RESERVED_TRACK_COUNT: layout.reserved_track_count = v;
      REG_SIDES_INTERLEAVED: begin
        word = {junk[7:1], v[0]};
        layout.sides_interleaved = v[0];
      end
      REG_RECORDS_PER_SECTOR: begin
        word = {junk[7], v[6:0]};
        layout.records_per_sector = v[6:0];
      end
      default: begin
        word = {junk[7:3], v[2:0]};
        layout.block_shift = v[2:0];
      end
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(negedge clk);
    while (cfg_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one request and books its expected result once accepted.
  // Valid stays high on return; the caller either sends again or lowers it.
  task automatic send_request(input logic k, input logic sd, input logic [7:0] trk,
                              input logic [7:0] cnt, input logic typed,
                              input position_t want);
    position_t predicted;
    in_valid     <= 1'b1;
    kind         <= k;
    side_in      <= sd;
    track_in     <= trk;
    sector_count <= cnt;
    @(negedge clk);
    while (in_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    predicted = predict_position(k, sd, trk, cnt);
    pending_positions = {pending_positions, (typed ? want : predicted)};
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every booked result has come back or the cap is reached.
  task automatic drain_positions(input int unsigned cap);
    int unsigned waited;
    waited   = 0;
    in_valid <= 1'b0;
    while (pending_positions.size() != 0 && waited < cap) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Result receiver: random stalls in bands, plus one long hold-off.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned band;
    logic        pressure_done;
    stall_left     = 0;
    pressure_done  = 1'b0;
    positions_seen = 0;
    out_ready      = 1'b0;
    forever begin
      @(negedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        check_position();
        positions_seen++;
      end
      @(posedge clk);
      if (!pressure_done && positions_seen >= 300) begin
        pressure_done = 1'b1;
        stall_left    = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        band = (positions_seen / 150) % 3;
        if (band == 1 && $urandom_range(0, 99) < 30) begin
          stall_left = $urandom_range(1, 3);
        end else if (band == 2) begin
          if ($urandom_range(0, 99) < 10) stall_left = $urandom_range(1, 3);
          else if ($urandom_range(0, 99) < 3) stall_left = $urandom_range(10, 50);
        end
      end
    end
  end

  // Hard limit on the whole run.
  initial begin : watchdog
    #50_000_000;
    $display("[disk_sector_position_tracker] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned phase_items;
    int unsigned r;
    int unsigned span;
    int          row;
    logic        burst;
    logic        k;
    logic        sd;
    logic [7:0]  trk;
    logic [7:0]  cnt;
    logic [7:0]  v;

    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    kind           = KIND_SET;
    side_in        = 1'b0;
    track_in       = '0;
    sector_count   = '0;
    mismatch_count = 0;
    random_sent    = 0;

    layout.sectors_per_track    = RST_SECTORS_PER_TRACK;
    layout.first_sector_id      = RST_FIRST_SECTOR_ID;
    layout.side_count           = RST_SIDE_COUNT;
    layout.track_count          = RST_TRACK_COUNT;
    layout.reserved_track_count = RST_RESERVED_TRACK_COUNT;
    layout.sides_interleaved    = RST_SIDES_INTERLEAVED;
    layout.records_per_sector   = RST_RECORDS_PER_SECTOR;
    layout.block_shift          = RST_BLOCK_SHIFT;
    head_side      = 1'b0;
    head_track     = '0;
    head_sector    = '0;
    head_block     = '0;
    disk_full_seen = 1'b0;

    // Reset layout: advancing from the reset sector gives a negative linear count.
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd0, 1'b1, {1'b0, 8'd0, 8'd0, 16'd0, 1'b0});
    add_req(KIND_SET, 1'b0, 8'd0, 8'd0, 1'b1, {1'b0, 8'd0, 8'd193, 16'd0, 1'b0});
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd8, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd1, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd255, 1'b0, '0);
    // Last track: the next carry runs off the disk.
    add_req(KIND_SET, 1'b0, 8'd39, 8'd0, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd9, 1'b0, '0);
    // Side one and a track beyond the count on a one-sided layout.
    add_req(KIND_SET, 1'b1, 8'd255, 8'd255, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b1, 8'd255, 8'd255, 1'b0, '0);
    // Largest geometry: block index saturates, and reserved tracks give zero.
    add_cfg(REG_SECTORS_PER_TRACK, 8'd127);
    add_cfg(REG_RECORDS_PER_SECTOR, 8'd127);
    add_cfg(REG_BLOCK_SHIFT, 8'd0);
    add_cfg(REG_SIDE_COUNT, 8'd3);
    add_cfg(REG_RESERVED_TRACK_COUNT, 8'd4);
    add_req(KIND_SET, 1'b0, 8'd255, 8'd0, 1'b1, {1'b0, 8'd255, 8'd193, 16'hFFFF, 1'b1});
    add_req(KIND_SET, 1'b1, 8'd3, 8'd0, 1'b1, {1'b1, 8'd3, 8'd193, 16'd0, 1'b1});
    // Degenerate layout: zero sectors, zero sides and zero tracks.
    add_cfg(REG_SECTORS_PER_TRACK, 8'd0);
    add_cfg(REG_SIDE_COUNT, 8'd0);
    add_cfg(REG_SIDES_INTERLEAVED, 8'd1);
    add_cfg(REG_TRACK_COUNT, 8'd0);
    add_cfg(REG_RESERVED_TRACK_COUNT, 8'd0);
    add_cfg(REG_FIRST_SECTOR_ID, 8'd255);
    add_cfg(REG_BLOCK_SHIFT, 8'd7);
    add_cfg(REG_RECORDS_PER_SECTOR, 8'd0);
    add_req(KIND_SET, 1'b0, 8'd0, 8'd0, 1'b1, {1'b0, 8'd0, 8'd255, 16'd0, 1'b1});
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd1, 1'b1, {1'b0, 8'd0, 8'd255, 16'd0, 1'b1});
    // Sector number wraps past eight bits within one track.
    add_cfg(REG_SECTORS_PER_TRACK, 8'd64);
    add_cfg(REG_TRACK_COUNT, 8'd255);
    add_cfg(REG_SIDE_COUNT, 8'd2);
    add_cfg(REG_SIDES_INTERLEAVED, 8'd0);
    add_cfg(REG_RECORDS_PER_SECTOR, 8'd4);
    add_cfg(REG_BLOCK_SHIFT, 8'd3);
    add_req(KIND_SET, 1'b1, 8'd0, 8'd0, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd30, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd200, 1'b0, '0);
    // Two sides, track first: change side, then run off the far side.
    add_cfg(REG_SECTORS_PER_TRACK, 8'd9);
    add_cfg(REG_FIRST_SECTOR_ID, 8'd1);
    add_cfg(REG_TRACK_COUNT, 8'd2);
    add_req(KIND_SET, 1'b0, 8'd1, 8'd0, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd9, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd18, 1'b0, '0);
    // Two sides, side first.
    add_cfg(REG_SIDES_INTERLEAVED, 8'd1);
    add_req(KIND_SET, 1'b0, 8'd0, 8'd0, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd9, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd9, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b0, 8'd0, 8'd40, 1'b0, '0);
    // Side one kept on a one-sided interleaved layout while the track steps.
    add_cfg(REG_SIDE_COUNT, 8'd1);
    add_cfg(REG_TRACK_COUNT, 8'd255);
    add_req(KIND_SET, 1'b1, 8'd5, 8'd0, 1'b0, '0);
    add_req(KIND_ADVANCE, 1'b1, 8'd0, 8'd9, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (row = 0; row < script.size(); row++) begin
      if (script[row].is_cfg) begin
        drain_positions(20000);
        write_register(script[row].reg_idx, script[row].reg_val);
      end else begin
        send_request(script[row].kind, script[row].side, script[row].track,
                     script[row].count, script[row].typed, script[row].want);
        pause_sender(pick_gap(1'b0));
      end
    end

    // Random phases, each under a freshly drawn layout.
    while (random_sent < 1700) begin
      drain_positions(20000);
      r = $urandom_range(0, 9);
      v = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'd127 : (r == 3) ? 8'd64
        : 8'($urandom_range(2, 18));
      write_register(REG_SECTORS_PER_TRACK, v);
      r = $urandom_range(0, 9);
      v = (r < 2) ? 8'd0 : (r == 2) ? 8'd255 : 8'($urandom_range(0, 255));
      write_register(REG_FIRST_SECTOR_ID, v);
      write_register(REG_SIDE_COUNT, 8'($urandom_range(0, 3)));
      r = $urandom_range(0, 9);
      v = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'd255
        : 8'($urandom_range(2, 40));
      write_register(REG_TRACK_COUNT, v);
      r = $urandom_range(0, 9);
      v = (r < 5) ? 8'd0 : (r < 8) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(0, 255));
      write_register(REG_RESERVED_TRACK_COUNT, v);
      write_register(REG_SIDES_INTERLEAVED, 8'($urandom_range(0, 1)));
      r = $urandom_range(0, 9);
      v = (r == 0) ? 8'd0 : (r == 1) ? 8'd127 : (r == 2) ? 8'd64
        : 8'($urandom_range(1, 8));
      write_register(REG_RECORDS_PER_SECTOR, v);
      write_register(REG_BLOCK_SHIFT, 8'($urandom_range(0, 7)));

      burst       = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(60, 140);
      repeat (phase_items) begin
        r   = $urandom_range(0, 99);
        sd  = 1'($urandom_range(0, 1));
        trk = 8'($urandom_range(0, 255));
        cnt = 8'($urandom_range(0, 255));
        // Mostly advances, most sized to the track, with some seeks onto the disk.
        if (r < 20) begin
          k = KIND_SET;
          if (r >= 5 && layout.track_count != 0)
            trk = 8'($urandom_range(0, layout.track_count - 1));
        end else begin
          k = KIND_ADVANCE;
          if (r >= 40) begin
            span = 2 * sectors_on_track() + 1;
            if (span > 255) span = 255;
            cnt = 8'($urandom_range(0, span));
          end
        end
        send_request(k, sd, trk, cnt, 1'b0, '0);
        random_sent++;
        pause_sender(pick_gap(burst));
      end
    end

    // Let the last results come back, then allow for a slow final advance.
    drain_positions(20000);
    repeat (600) @(posedge clk);
    if (pending_positions.size() != 0) begin
      $error("%0d expected results never arrived", pending_positions.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[disk_sector_position_tracker] OK");
    end else begin
      $display("[disk_sector_position_tracker] ERROR");
    end
    $finish;
  end

endmodule
